// ===== src/hsl_pkg.sv =====
`default_nettype none

package hsl_pkg;

    // Hue sector bounds, in degrees
    localparam logic [8:0] HueGreen = 9'd120;
    localparam logic [8:0] HueBlue  = 9'd240;
    localparam logic [8:0] HueFull  = 9'd360;

    // A ramp of 0..RampMax stands for a weight of 0..1
    localparam int unsigned RampMax = 60;
    localparam int unsigned RampW   = 6;

    // Common denominator 255 * 60
    localparam logic [13:0] LevelDen = 14'd15300;

    localparam int unsigned ChromaW = 15;   // 2*S*r + 60*(255-S), at most 30600
    localparam int unsigned GreyW   = 14;   // 60*(255-S), at most 15300
    localparam int unsigned ScaleW  = 7;    // L, or 255-L, at most 127
    localparam int unsigned NumW    = 22;   // numerator, at most 255*15300

    // floor(n / 15300) == (n * LevelRecip) >> QuotShift for every n below 2^22
    localparam int unsigned RecipW     = 23;
    localparam logic [22:0] LevelRecip = 23'd4491470;
    localparam int unsigned QuotShift  = 36;
    localparam int unsigned ProdW      = NumW + RecipW;

    localparam int unsigned Lanes = 3;     // red, green, blue

    // Contents of the first pipeline register
    typedef struct packed {
        logic [15:0]                  pixel_index;
        logic                         index_ok;
        logic [Lanes-1:0][RampW-1:0]  ramp;      // [0] red, [1] green, [2] blue
        logic [7:0]                   sat;
        logic [GreyW-1:0]             grey;
        logic [ScaleW-1:0]            scale;
        logic [NumW-1:0]              offset;
    } ramp_stage_t;

    // Load enables of the lane stages
    typedef struct packed {
        logic chroma;
        logic numer;
        logic quot;
    } lane_en_t;

endpackage

`default_nettype wire

// ===== src/hsl_ramp.sv =====
`default_nettype none

module hsl_ramp (
    input  wire                      aclk,
    input  wire                      en,
    input  wire  [15:0]              pixel_index,
    input  wire  [8:0]               hue_degrees,
    input  wire  [7:0]               saturation_level,
    input  wire  [7:0]               lightness_level,
    input  wire  [15:0]              pixel_count,
    output hsl_pkg::ramp_stage_t     stage_out
);

    // Clamp a signed ramp to 0..60
    function automatic logic [hsl_pkg::RampW-1:0] clamp_ramp(input logic signed [10:0] v);
        logic [hsl_pkg::RampW-1:0] res;
        if (v < 11'sd0) begin
            res = '0;
        end else if (v > 11'(hsl_pkg::RampMax)) begin
            res = hsl_pkg::RampW'(hsl_pkg::RampMax);
        end else begin
            res = v[hsl_pkg::RampW-1:0];
        end
        return res;
    endfunction

    logic signed [10:0]     hue_s;
    logic [8:0]             dbl_l;
    hsl_pkg::ramp_stage_t   stage_reg;
    hsl_pkg::ramp_stage_t   stage_next;

    assign hue_s = signed'({2'b00, hue_degrees});
    assign dbl_l = {lightness_level, 1'b0} - 9'd255;

    always_comb begin
        stage_next             = '0;
        stage_next.pixel_index = pixel_index;
        stage_next.index_ok    = (pixel_index < pixel_count);
        stage_next.sat         = saturation_level;
        stage_next.grey        = hsl_pkg::GreyW'(14'd60 * {6'd0, 8'd255 - saturation_level});

        if (hue_degrees < hsl_pkg::HueGreen) begin
            stage_next.ramp[0] = clamp_ramp(signed'({2'b00, hsl_pkg::HueGreen}) - hue_s);
            stage_next.ramp[1] = clamp_ramp(hue_s);
            stage_next.ramp[2] = '0;
        end else if (hue_degrees < hsl_pkg::HueBlue) begin
            stage_next.ramp[0] = '0;
            stage_next.ramp[1] = clamp_ramp(signed'({2'b00, hsl_pkg::HueBlue}) - hue_s);
            stage_next.ramp[2] = clamp_ramp(hue_s - signed'({2'b00, hsl_pkg::HueGreen}));
        end else begin
            // past 360 the blue ramp goes negative and clamps to zero
            stage_next.ramp[0] = clamp_ramp(hue_s - signed'({2'b00, hsl_pkg::HueBlue}));
            stage_next.ramp[1] = '0;
            stage_next.ramp[2] = clamp_ramp(signed'({2'b00, hsl_pkg::HueFull}) - hue_s);
        end

        // dark half scales; light half blends toward white
        if (lightness_level[7] == 1'b0) begin
            stage_next.scale  = lightness_level[6:0];
            stage_next.offset = '0;
        end else begin
            stage_next.scale  = 7'(8'd255 - lightness_level);
            stage_next.offset = hsl_pkg::NumW'({13'd0, dbl_l} * {8'd0, hsl_pkg::LevelDen});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

`default_nettype wire

// ===== src/hsl_lane.sv =====
`default_nettype none

module hsl_lane (
    input  wire                              aclk,
    input  hsl_pkg::lane_en_t                en,
    input  wire  [hsl_pkg::RampW-1:0]        ramp,
    input  wire  [7:0]                       sat,
    input  wire  [hsl_pkg::GreyW-1:0]        grey,
    input  wire  [hsl_pkg::ScaleW-1:0]       scale,
    input  wire  [hsl_pkg::NumW-1:0]         offset,
    output logic [7:0]                       level
);

    logic [13:0]                 sat_ramp;
    logic [15:0]                 chroma_sum;
    logic [hsl_pkg::ChromaW-1:0] chroma_reg;
    logic [hsl_pkg::NumW:0]      numer_sum;
    logic [hsl_pkg::NumW-1:0]    numer_reg;
    logic [hsl_pkg::ProdW-1:0]   prod_next;
    logic [hsl_pkg::ProdW-1:0]   prod_reg;

    // chroma: 2*S*r + 60*(255-S)
    assign sat_ramp   = {6'd0, sat} * {8'd0, ramp};
    assign chroma_sum = {1'b0, sat_ramp, 1'b0} + {2'b00, grey};

    // numerator over 15300
    assign numer_sum = {1'b0, {15'd0, scale} * {7'd0, chroma_reg}} + {1'b0, offset};

    // divide by 15300 through the reciprocal
    assign prod_next = {{hsl_pkg::RecipW{1'b0}}, numer_reg}
                     * {{hsl_pkg::NumW{1'b0}}, hsl_pkg::LevelRecip};

    always_ff @(posedge aclk) begin
        if (en.chroma) begin
            chroma_reg <= chroma_sum[hsl_pkg::ChromaW-1:0];
        end
        if (en.numer) begin
            numer_reg <= numer_sum[hsl_pkg::NumW-1:0];
        end
        if (en.quot) begin
            prod_reg <= prod_next;
        end
    end

    assign level = prod_reg[hsl_pkg::QuotShift +: 8];

endmodule

`default_nettype wire

// ===== src/hsl_to_rgb_converter.sv =====
// HSL to RGB pixel converter, 8 bits per channel.
//
// Input stream (s_): one request per pixel, hue in degrees, saturation and
// lightness. Output stream (m_): the pixel index unchanged, red, green and
// blue levels, and in m_tuser a flag that is set when the index lies below
// the configured strip length.
// cfg_wen / cfg_wdata write the strip length (pixel count); write it only
// while no request is in flight. A count of zero marks every index invalid.
//
// Throughput: one request per cycle while the receiver keeps m_tready high, set
// by the five-stage pipeline (ramps, chroma, numerator, reciprocal multiply,
// output register), each stage holding one multiplier per colour lane at most.
// An accepted request passes through these stages in order to m_tvalid.
// Reset (aresetn low, synchronous) empties the pipeline and sets the pixel
// count to one. When the receiver stalls, the output register holds its
// request and each stage holds once the stage after it is full; bubbles
// still close up, so s_tready stays high until all five stages are full.
`default_nettype none

module hsl_to_rgb_converter (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         cfg_wen,
    input  wire  [15:0] cfg_wdata,

    input  wire         s_tvalid,
    output logic        s_tready,
    // pixel_index [15:0], hue_degrees [24:16], saturation_level [32:25],
    // lightness_level [40:33], zero [47:41]
    input  wire  [47:0] s_tdata,

    output logic        m_tvalid,
    input  wire         m_tready,
    // out_index [15:0], red_level [23:16], green_level [31:24], blue_level [39:32]
    output logic [39:0] m_tdata,
    // index_ok [0]
    output logic        m_tuser
);

    logic [15:0]                pixel_count_reg;

    // stage valids: ramp, chroma, numerator, quotient, output
    logic                       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                       rdy1, rdy2, rdy3, rdy4, rdy5;
    hsl_pkg::lane_en_t          lane_en;

    hsl_pkg::ramp_stage_t       st1;

    // side band carried alongside the lanes
    logic [15:0]                idx2_reg, idx3_reg, idx4_reg;
    logic                       ok2_reg, ok3_reg, ok4_reg;
    logic [hsl_pkg::ScaleW-1:0] scale2_reg;
    logic [hsl_pkg::NumW-1:0]   offset2_reg;

    logic [hsl_pkg::Lanes-1:0][7:0] lane_level;
    logic [39:0]                m_tdata_reg;
    logic                       m_tuser_reg;

    // A stage takes a new request when it is empty or its contents move on
    assign rdy5 = !v5_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_tready = rdy1;

    assign lane_en.chroma = rdy2;
    assign lane_en.numer  = rdy3;
    assign lane_en.quot   = rdy4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= 16'd1;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
        end else begin
            if (cfg_wen) begin
                pixel_count_reg <= cfg_wdata;
            end
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Stage 1: sector ramps, grey term, lightness scale and offset, index check
    hsl_ramp u_ramp (
        .aclk             (aclk),
        .en               (rdy1),
        .pixel_index      (s_tdata[15:0]),
        .hue_degrees      (s_tdata[24:16]),
        .saturation_level (s_tdata[32:25]),
        .lightness_level  (s_tdata[40:33]),
        .pixel_count      (pixel_count_reg),
        .stage_out        (st1)
    );

    // Advance the pass-through fields in step with the lanes
    always_ff @(posedge aclk) begin
        if (rdy2) begin
            idx2_reg    <= st1.pixel_index;
            ok2_reg     <= st1.index_ok;
            scale2_reg  <= st1.scale;
            offset2_reg <= st1.offset;
        end
        if (rdy3) begin
            idx3_reg <= idx2_reg;
            ok3_reg  <= ok2_reg;
        end
        if (rdy4) begin
            idx4_reg <= idx3_reg;
            ok4_reg  <= ok3_reg;
        end
    end

    // Stages 2 to 4: one lane per colour
    for (genvar g = 0; g < hsl_pkg::Lanes; g++) begin : g_lane
        hsl_lane u_lane (
            .aclk   (aclk),
            .en     (lane_en),
            .ramp   (st1.ramp[g]),
            .sat    (st1.sat),
            .grey   (st1.grey),
            .scale  (scale2_reg),
            .offset (offset2_reg),
            .level  (lane_level[g])
        );
    end

    // Stage 5: output register, held while the receiver stalls
    always_ff @(posedge aclk) begin
        if (rdy5) begin
            m_tdata_reg <= {lane_level[2], lane_level[1], lane_level[0], idx4_reg};
            m_tuser_reg <= ok4_reg;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
